@@ design/gdi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdi_pkg: shared types and tables of the date information core
// Field widths, the entry moved between front and back, and the month tables.
// ----------------------------------------------------------------------------
package gdi_pkg;

	localparam int YEAR_W   = 14;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int WDAY_W   = 3;
	localparam int MLEN_W   = 5;
	localparam int YDAYS_W  = 9;
	localparam int YS_W     = 15;
	localparam int Q4_W     = 13;
	localparam int Q100_W   = 8;
	localparam int MTERM_W  = 6;
	localparam int SUM_W    = 15;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	localparam logic [WDAY_W-1:0] WD_SUN = 3'd0;
	localparam logic [WDAY_W-1:0] WD_SAT = 3'd6;

	// One classified date waiting for the weekday arithmetic.
	typedef struct packed {
		logic [YS_W-1:0]    ys;
		logic [Q4_W-1:0]    q4;
		logic [Q100_W-1:0]  q100;
		logic [MTERM_W-1:0] mterm;
		logic [DAY_W-1:0]   day;
		logic [MLEN_W-1:0]  mlen;
		logic [MLEN_W-1:0]  to_month;
		logic [YDAYS_W-1:0] to_year;
		logic               invalid;
	} gdi_entry_t;

	typedef struct packed {
		logic [Q100_W:0] q;
		logic [4:0]      r;
	} gdi_div25_t;

	// Division by 25 through a slightly low reciprocal and one correction step.
	function automatic gdi_div25_t div25(input logic [Q4_W-1:0] x);
		logic [Q4_W+11:0] prod;
		logic [Q100_W:0]  q;
		logic [Q4_W-1:0]  r;
		gdi_div25_t       res;
		prod = x * 12'd2621;
		q    = prod[Q4_W+11:16];
		r    = x - Q4_W'(q) * Q4_W'(25);
		if (r >= Q4_W'(25)) begin
			q = q + 1'b1;
			r = r - Q4_W'(25);
		end
		res.q = q;
		res.r = r[4:0];
		return res;
	endfunction

	// Length of a month in a common year, zero outside January to December.
	function automatic logic [MLEN_W-1:0] month_len_base(input logic [MONTH_W-1:0] m);
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len_base = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    month_len_base = 5'd30;
			4'd2:                                       month_len_base = 5'd28;
			default:                                    month_len_base = 5'd0;
		endcase
	endfunction

	// floor(2.6 * shifted_month - 0.2), where March counts as 1 and January and February count as 11 and 12.
	function automatic logic [MTERM_W-1:0] month_term(input logic [MONTH_W-1:0] m);
		case (m)
			4'd0:    month_term = 6'd25;
			4'd1:    month_term = 6'd28;
			4'd2:    month_term = 6'd31;
			4'd3:    month_term = 6'd2;
			4'd4:    month_term = 6'd5;
			4'd5:    month_term = 6'd7;
			4'd6:    month_term = 6'd10;
			4'd7:    month_term = 6'd12;
			4'd8:    month_term = 6'd15;
			4'd9:    month_term = 6'd18;
			4'd10:   month_term = 6'd20;
			4'd11:   month_term = 6'd23;
			4'd12:   month_term = 6'd25;
			4'd13:   month_term = 6'd28;
			4'd14:   month_term = 6'd31;
			default: month_term = 6'd33;
		endcase
	endfunction

	// Days in all months after the given one, common year.
	function automatic logic [YDAYS_W-1:0] days_after(input logic [MONTH_W-1:0] m);
		case (m)
			4'd1:    days_after = 9'd334;
			4'd2:    days_after = 9'd306;
			4'd3:    days_after = 9'd275;
			4'd4:    days_after = 9'd245;
			4'd5:    days_after = 9'd214;
			4'd6:    days_after = 9'd184;
			4'd7:    days_after = 9'd153;
			4'd8:    days_after = 9'd122;
			4'd9:    days_after = 9'd92;
			4'd10:   days_after = 9'd61;
			4'd11:   days_after = 9'd31;
			default: days_after = 9'd0;
		endcase
	endfunction

endpackage

@@ design/gregorian_date_info_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_info_core: Gregorian date information
// Day of week, weekend and business-day flags, month length and remaining
// days in the week, month and year for one date per beat.
// ----------------------------------------------------------------------------
// Usage:
// A date beat (year, month, day) enters when push is high and full is low.
// The front checks the date and writes it into a short queue in the same
// cycle; the back end takes the oldest queued date, sums the weekday terms
// in one stage and reduces modulo seven into the result register.
// A result beat is shown while empty is low and leaves when pop is high.
// An accepted date passes from the queue through the sum stage into the result register before empty goes low.
// Throughput is one date per cycle while the receiver pops, set by the two-stage back pipeline
// fed from the queue once per cycle.
// When the receiver stalls, the result holds, the back stages fill, and the
// queue absorbs QUEUE_DEPTH more dates before full rises.
// Reset empties the queue and the pipeline; no result is shown after it.
// An invalid date still reports the formula weekday, with zero remaining
// month and year days.
// ----------------------------------------------------------------------------
module gregorian_date_info_core import gdi_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [YEAR_W-1:0]  year,
	input  logic [MONTH_W-1:0] month,
	input  logic [DAY_W-1:0]   day,
	output logic               empty,
	input  logic               pop,
	output logic [WDAY_W-1:0]  weekday,
	output logic               end_of_week,
	output logic               weekend,
	output logic               business_day,
	output logic [WDAY_W-1:0]  to_week_end,
	output logic [MLEN_W-1:0]  month_length,
	output logic [MLEN_W-1:0]  to_month_end,
	output logic [YDAYS_W-1:0] to_year_end,
	output logic               date_invalid
);

	gdi_entry_t front_entry;
	gdi_entry_t queue_entry;
	logic       queue_valid;
	logic       back_take;

	gdi_front u_front (
		.year  (year),
		.month (month),
		.day   (day),
		.entry (front_entry)
	);

	gdi_queue #(
		.WIDTH ($bits(gdi_entry_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (push && !full),
		.wr_data   (front_entry),
		.full      (full),
		.rd_en     (back_take && queue_valid),
		.rd_data   (queue_entry),
		.not_empty (queue_valid)
	);

	gdi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.entry        (queue_entry),
		.entry_valid  (queue_valid),
		.take         (back_take),
		.pop          (pop),
		.empty        (empty),
		.weekday      (weekday),
		.end_of_week  (end_of_week),
		.weekend      (weekend),
		.business_day (business_day),
		.to_week_end  (to_week_end),
		.month_length (month_length),
		.to_month_end (to_month_end),
		.to_year_end  (to_year_end),
		.date_invalid (date_invalid)
	);

endmodule

@@ design/gdi_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdi_front: date classification
// Checks the date, finds the month length and remaining days, and prepares
// the year terms of the weekday formula.
// ----------------------------------------------------------------------------
module gdi_front import gdi_pkg::*; (
	input  logic [YEAR_W-1:0]  year,
	input  logic [MONTH_W-1:0] month,
	input  logic [DAY_W-1:0]   day,
	output gdi_entry_t         entry
);

	logic               early;
	logic [YS_W-1:0]    ys;
	logic [Q4_W-1:0]    ys_q4;
	gdi_div25_t         ys_d;
	gdi_div25_t         y_d;
	logic               div4;
	logic               div100;
	logic               div400;
	logic               leap;
	logic [MLEN_W-1:0]  mlen;
	logic               invalid;
	logic [MLEN_W-1:0]  to_month;
	logic [YDAYS_W-1:0] to_year;

	always_comb begin
		early = (month <= MONTH_FEB);
		// Shifting by 400 years keeps the weekday and keeps the value positive.
		ys    = YS_W'(year) + YS_W'(400) - YS_W'(early);
		ys_q4 = ys[YS_W-1:2];
		ys_d  = div25(ys_q4);

		y_d    = div25(Q4_W'(year[YEAR_W-1:2]));
		div4   = (year[1:0] == 2'b00);
		div100 = div4 && (y_d.r == 5'd0);
		div400 = div100 && (y_d.q[1:0] == 2'b00);
		leap   = div400 || (div4 && !div100);

		mlen = month_len_base(month) + MLEN_W'(leap && (month == MONTH_FEB));
		invalid = (mlen == '0) || (day == '0) || (day > mlen);

		to_month = invalid ? '0 : (mlen - day);
		to_year  = invalid ? '0 : (YDAYS_W'(to_month) + days_after(month)
		                           + YDAYS_W'(leap && (month == MONTH_JAN)));

		entry.ys       = ys;
		entry.q4       = ys_q4;
		entry.q100     = ys_d.q[Q100_W-1:0];
		entry.mterm    = month_term(month);
		entry.day      = day;
		entry.mlen     = mlen;
		entry.to_month = to_month;
		entry.to_year  = to_year;
		entry.invalid  = invalid;
	end

endmodule

@@ design/gdi_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdi_queue: short first-in first-out queue
// Decouples the classification front from the weekday back end.
// ----------------------------------------------------------------------------
module gdi_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             not_empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [WIDTH-1:0] slots_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign rd_data   = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			slots_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/gdi_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdi_back: weekday pipeline
// Sums the formula terms, reduces modulo seven and holds the result beat.
// ----------------------------------------------------------------------------
module gdi_back import gdi_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  gdi_entry_t         entry,
	input  logic               entry_valid,
	output logic               take,
	input  logic               pop,
	output logic               empty,
	output logic [WDAY_W-1:0]  weekday,
	output logic               end_of_week,
	output logic               weekend,
	output logic               business_day,
	output logic [WDAY_W-1:0]  to_week_end,
	output logic [MLEN_W-1:0]  month_length,
	output logic [MLEN_W-1:0]  to_month_end,
	output logic [YDAYS_W-1:0] to_year_end,
	output logic               date_invalid
);

	logic               valid_s1;
	logic [SUM_W-1:0]   sum_s1;
	logic [MLEN_W-1:0]  mlen_s1;
	logic [MLEN_W-1:0]  to_month_s1;
	logic [YDAYS_W-1:0] to_year_s1;
	logic               invalid_s1;
	logic               valid_s2;
	logic               adv1;
	logic               adv2;
	logic [SUM_W-1:0]   sum;
	logic [SUM_W+13:0]  prod;
	logic [SUM_W-1:0]   q7;
	logic [SUM_W-1:0]   rem;
	logic [WDAY_W-1:0]  wd;

	assign adv2  = !valid_s2 || pop;
	assign adv1  = !valid_s1 || adv2;
	assign take  = adv1;
	assign empty = !valid_s2;

	// The subtraction cannot go negative because ys/4 is never below ys/100.
	assign sum = SUM_W'(entry.day) + entry.ys + SUM_W'(entry.q4)
	           + SUM_W'(entry.q100[Q100_W-1:2]) + SUM_W'(entry.mterm)
	           - SUM_W'(entry.q100);

	always_comb begin
		// The reciprocal is slightly low, so the remainder needs at most one fix.
		prod = sum_s1 * 14'd9362;
		q7   = SUM_W'(prod[SUM_W+13:16]);
		rem  = sum_s1 - SUM_W'(q7 * 3'd7);
		if (rem >= SUM_W'(7)) begin
			rem = rem - SUM_W'(7);
		end
		wd = rem[WDAY_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv1) begin
				valid_s1 <= entry_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && entry_valid) begin
			sum_s1      <= sum;
			mlen_s1     <= entry.mlen;
			to_month_s1 <= entry.to_month;
			to_year_s1  <= entry.to_year;
			invalid_s1  <= entry.invalid;
		end
		if (adv2 && valid_s1) begin
			weekday      <= wd;
			end_of_week  <= (wd == WD_SAT);
			weekend      <= (wd == WD_SAT) || (wd == WD_SUN);
			business_day <= !((wd == WD_SAT) || (wd == WD_SUN));
			to_week_end  <= WD_SAT - wd;
			month_length <= mlen_s1;
			to_month_end <= to_month_s1;
			to_year_end  <= to_year_s1;
			date_invalid <= invalid_s1;
		end
	end

endmodule

@@ design/gdi_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdi_checker: port-level checks of the date information core
// Watches the result channel for consistent fields and stable stalled beats.
// ----------------------------------------------------------------------------
module gdi_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic [2:0] weekday,
	input logic       end_of_week,
	input logic       weekend,
	input logic       business_day,
	input logic [2:0] to_week_end,
	input logic [4:0] month_length,
	input logic [4:0] to_month_end,
	input logic [8:0] to_year_end,
	input logic       date_invalid
);

	a_weekday_flags: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (weekday <= 3'd6) && (end_of_week == (weekday == 3'd6))
		        && (weekend == ((weekday == 3'd6) || (weekday == 3'd0)))
		        && (business_day == !weekend))
		else $error("weekday flags disagree with the weekday");

	a_week_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (to_week_end == 3'd6 - weekday))
		else $error("days to week end disagree with the weekday");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && date_invalid) |-> (to_month_end == '0) && (to_year_end == '0))
		else $error("invalid date reports remaining days");

	a_month_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !date_invalid) |-> (to_month_end < month_length)
		                           && (9'(to_month_end) <= to_year_end))
		else $error("remaining days exceed the month or the year");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty && $stable(weekday) && $stable(to_year_end))
		else $error("stalled result beat changed");

endmodule

bind gregorian_date_info_core gdi_checker u_gdi_checker (.*);
